>>> rtl/impulse_collision_2d_unit_macros.svh
// ----------------------------------------------------------------------------
// Impulse collision 2D assertion macros
// Shorthand for the clocked, reset-gated assertions of the collision unit.
// ----------------------------------------------------------------------------
`ifndef IMPULSE_COLLISION_2D_UNIT_MACROS_SVH
`define IMPULSE_COLLISION_2D_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define IC2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IC2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ic2d_pkg.sv
// ----------------------------------------------------------------------------
// Impulse collision 2D package
// Payload types, fixed-point constants and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package ic2d_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  // 1e-6 in the squared-speed format, rounded
  localparam longint unsigned REST_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

  localparam logic [30:0] ONE30 = 31'h4000_0000;
  localparam logic [15:0] E_MAX = 16'h8000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_REST = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] normal_x;
    logic signed [DATA_W-1:0] normal_y;
    logic        [DATA_W-1:0] mass_a;
    logic signed [DATA_W-1:0] vel_a_x;
    logic signed [DATA_W-1:0] vel_a_y;
    logic        [DATA_W-1:0] mass_b;
    logic signed [DATA_W-1:0] vel_b_x;
    logic signed [DATA_W-1:0] vel_b_y;
  } ic2d_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] new_vel_a_x;
    logic signed [DATA_W-1:0] new_vel_a_y;
    logic signed [DATA_W-1:0] new_vel_b_x;
    logic signed [DATA_W-1:0] new_vel_b_y;
    logic        [1:0]        status;
  } ic2d_out_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic nb, logic [31:0] den);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {rem, nb};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, diff[31:0]};
    end
    return {1'b0, t[31:0]};
  endfunction

  // Shift right by 30, round to nearest with ties away from zero
  function automatic logic signed [41:0] rnd30(logic signed [71:0] p);
    logic [71:0] mg;
    logic [71:0] r;
    mg = p[71] ? 72'(-p) : 72'(p);
    r  = (mg + 72'd536870912) >> 30;
    return p[71] ? -$signed(r[41:0]) : $signed(r[41:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_out(logic signed [39:0] x);
    if (x > $signed(40'h00_7FFF_FFFF)) begin
      return $signed(32'h7FFF_FFFF);
    end
    if (x < $signed(40'hFF_8000_0000)) begin
      return $signed(32'h8000_0000);
    end
    return x[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/impulse_collision_2d_unit.sv
// ----------------------------------------------------------------------------
// Impulse collision 2D unit
// Restitution impulse between two bodies along a normalised contact normal.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one contact (normal, masses,
// velocities) per transfer. Output channel: out_valid_o / out_stall_i carry the
// new velocities and a status code (ok, both at rest, zero normal or zero total mass).
// The restitution register is to be written through cfg_we_i / cfg_wdata_i only
// while the unit is idle; the unit does not enforce this. Values above 1.0 act as 1.0.
// One contact can enter every cycle unless the output stalls; the 32-step
// square root and the three 31-step dividers are fully unrolled pipelines, so
// the sustained rate is one item per cycle while the receiver takes results.
// Reset clears every stage valid bit and sets restitution to 1.0.
// While the output register holds an untaken result and the receiver stalls,
// the whole pipeline freezes and in_stall_o is raised; nothing is dropped.
// ----------------------------------------------------------------------------
`include "impulse_collision_2d_unit_macros.svh"

module impulse_collision_2d_unit
  import ic2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ic2d_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ic2d_out_t out_data_o
);

  localparam int SQ_N = 32;
  localparam int DV_N = 31;

  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    status_e            status;
    logic               sx;
    logic               sy;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] m;
    logic [31:0] mb2;
    logic [31:0] t2;
  } s2_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] cx;
    logic [30:0] cy;
    logic [31:0] mb2;
    logic [31:0] t2;
  } s3_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] cx;
    logic [30:0] cy;
    logic [61:0] xsq;
    logic [61:0] ysq;
    logic [31:0] mb2;
    logic [31:0] t2;
  } s4_t;

  typedef struct packed {
    side_t       side;
    logic [30:0] cx;
    logic [30:0] cy;
    logic [31:0] mb2;
    logic [31:0] t2;
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] mag;
    logic [31:0] t2;
    logic [61:0] nx_num;
    logic [61:0] ny_num;
    logic [62:0] m_num;
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rm;
    logic [30:0] qx;
    logic [30:0] qy;
    logic [30:0] qm;
  } dv_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic        [31:0] ga;
    logic        [31:0] gb;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
  } g_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic        [31:0] ga;
    logic        [31:0] gb;
    logic signed [64:0] pdx;
    logic signed [64:0] pdy;
  } h_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic        [31:0] ga;
    logic        [31:0] gb;
    logic signed [35:0] d;
  } i_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [68:0] qa;
    logic signed [68:0] qb;
  } j_t;

  typedef struct packed {
    side_t              side;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [37:0] pa;
    logic signed [37:0] pb;
  } k_t;

  typedef struct packed {
    side_t              side;
    logic signed [69:0] pax;
    logic signed [69:0] pay;
    logic signed [69:0] pbx;
    logic signed [69:0] pby;
  } l_t;

  logic        en;
  logic [15:0] restitution_q;

  ic2d_in_t  s1_q;
  s2_t       s2_q;
  s3_t       s3_q;
  s4_t       s4_q;
  sq_t       sq_q [SQ_N+1];
  dv_t       dv_q [DV_N+1];
  g_t        g_q;
  h_t        h_q;
  i_t        i_q;
  j_t        j_q;
  k_t        k_q;
  l_t        l_q;
  ic2d_out_t out_q;

  logic              s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [SQ_N:0]     sq_vld_q;
  logic [DV_N:0]     dv_vld_q;
  logic              g_vld_q, h_vld_q, i_vld_q, j_vld_q, k_vld_q, l_vld_q;
  logic              out_valid_q;

  s2_t s2_d;
  s3_t s3_d;
  g_t  g_d;
  ic2d_out_t out_d;

  // Advance everything unless a finished result is waiting on a stalled receiver
  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic at_rest(logic signed [31:0] vx, logic signed [31:0] vy);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [30:0] s;
    ax = mag32(vx);
    ay = mag32(vy);
    if (ax[31:15] != 17'd0 || ay[31:15] != 17'd0) begin
      return 1'b0;
    end
    s = 31'(30'(ax[14:0]) * 30'(ax[14:0])) + 31'(30'(ay[14:0]) * 30'(ay[14:0]));
    return s < 31'(REST_LIMIT);
  endfunction

  function automatic sq_t sq_step(sq_t s, int i);
    sq_t         r;
    logic [63:0] trial;
    r     = s;
    trial = ({32'd0, s.root} << (i + 1)) | (64'd1 << (2 * i));
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = s.root | (32'd1 << i);
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t s, int b);
    dv_t         r;
    logic [32:0] tx;
    logic [32:0] ty;
    logic [32:0] tm;
    r    = s;
    tx   = div_step(s.rx, s.nx_num[b], s.mag);
    ty   = div_step(s.ry, s.ny_num[b], s.mag);
    tm   = div_step(s.rm, s.m_num[b], s.t2);
    r.rx = tx[31:0];
    r.ry = ty[31:0];
    r.rm = tm[31:0];
    r.qx = {s.qx[29:0], tx[32]};
    r.qy = {s.qy[29:0], ty[32]};
    r.qm = {s.qm[29:0], tm[32]};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restitution_q <= E_MAX;
    end else if (cfg_we_i) begin
      restitution_q <= cfg_wdata_i;
    end
  end

  // Magnitudes, mass prescale and special cases
  always_comb begin
    logic [32:0] tot;
    s2_d.side.vax = s1_q.vel_a_x;
    s2_d.side.vay = s1_q.vel_a_y;
    s2_d.side.vbx = s1_q.vel_b_x;
    s2_d.side.vby = s1_q.vel_b_y;
    s2_d.side.sx  = s1_q.normal_x[31];
    s2_d.side.sy  = s1_q.normal_y[31];
    s2_d.cx       = mag32(s1_q.normal_x);
    s2_d.cy       = mag32(s1_q.normal_y);
    s2_d.m        = (s2_d.cx > s2_d.cy) ? s2_d.cx : s2_d.cy;
    tot           = {1'b0, s1_q.mass_a} + {1'b0, s1_q.mass_b};
    s2_d.mb2      = tot[32] ? {1'b0, s1_q.mass_b[31:1]} : s1_q.mass_b;
    s2_d.t2       = tot[32] ? 32'(tot[32:1] - 33'(s1_q.mass_a[0] & s1_q.mass_b[0])) : tot[31:0];
    if (at_rest(s1_q.vel_a_x, s1_q.vel_a_y) && at_rest(s1_q.vel_b_x, s1_q.vel_b_y)) begin
      s2_d.side.status = ST_REST;
    end else if (s2_d.m == 32'd0 || tot == 33'd0) begin
      s2_d.side.status = ST_ZERO;
    end else begin
      s2_d.side.status = ST_OK;
    end
  end

  // Normalise the larger normal component into [2^30, 2^31)
  always_comb begin
    logic [4:0] sh;
    sh = '0;
    for (int k = 0; k < 31; k++) begin
      if (s2_q.m[k]) begin
        sh = 5'(30 - k);
      end
    end
    s3_d.side = s2_q.side;
    s3_d.mb2  = s2_q.mb2;
    s3_d.t2   = s2_q.t2;
    if (s2_q.m[31]) begin
      s3_d.cx = s2_q.cx[31:1];
      s3_d.cy = s2_q.cy[31:1];
    end else begin
      s3_d.cx = 31'(s2_q.cx << sh);
      s3_d.cy = 31'(s2_q.cy << sh);
    end
  end

  // Gains and velocity difference
  always_comb begin
    logic [30:0] ra;
    logic [30:0] rb;
    logic [15:0] e;
    logic [16:0] f;
    logic [47:0] pa48;
    logic [47:0] pb48;
    dv_t         dv;
    dv      = dv_q[DV_N];
    ra      = dv.qm;
    rb      = ONE30 - ra;
    e       = (restitution_q > E_MAX) ? E_MAX : restitution_q;
    f       = 17'(E_MAX) + 17'(e);
    pa48    = 48'(ra) * 48'(f) + 48'd16384;
    pb48    = 48'(rb) * 48'(f) + 48'd16384;
    g_d.side = dv.side;
    g_d.ux   = dv.side.sx ? -$signed({1'b0, dv.qx}) : $signed({1'b0, dv.qx});
    g_d.uy   = dv.side.sy ? -$signed({1'b0, dv.qy}) : $signed({1'b0, dv.qy});
    g_d.ga   = pa48[46:15];
    g_d.gb   = pb48[46:15];
    g_d.dx   = 33'(dv.side.vbx) - 33'(dv.side.vax);
    g_d.dy   = 33'(dv.side.vby) - 33'(dv.side.vay);
  end

  // Apply the impulse, saturate; pass velocities through on a special case
  always_comb begin
    logic signed [39:0] ax;
    logic signed [39:0] ay;
    logic signed [39:0] bx;
    logic signed [39:0] by;
    ax = 40'(l_q.side.vax) + 40'(rnd30(72'(l_q.pax)));
    ay = 40'(l_q.side.vay) + 40'(rnd30(72'(l_q.pay)));
    bx = 40'(l_q.side.vbx) - 40'(rnd30(72'(l_q.pbx)));
    by = 40'(l_q.side.vby) - 40'(rnd30(72'(l_q.pby)));
    out_d.status = l_q.side.status;
    if (l_q.side.status == ST_OK) begin
      out_d.new_vel_a_x = sat_out(ax);
      out_d.new_vel_a_y = sat_out(ay);
      out_d.new_vel_b_x = sat_out(bx);
      out_d.new_vel_b_y = sat_out(by);
    end else begin
      out_d.new_vel_a_x = l_q.side.vax;
      out_d.new_vel_a_y = l_q.side.vay;
      out_d.new_vel_b_x = l_q.side.vbx;
      out_d.new_vel_b_y = l_q.side.vby;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      s4_vld_q    <= 1'b0;
      sq_vld_q    <= '0;
      dv_vld_q    <= '0;
      g_vld_q     <= 1'b0;
      h_vld_q     <= 1'b0;
      i_vld_q     <= 1'b0;
      j_vld_q     <= 1'b0;
      k_vld_q     <= 1'b0;
      l_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_vld_q    <= in_valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      sq_vld_q    <= {sq_vld_q[SQ_N-1:0], s4_vld_q};
      dv_vld_q    <= {dv_vld_q[DV_N-1:0], sq_vld_q[SQ_N]};
      g_vld_q     <= dv_vld_q[DV_N];
      h_vld_q     <= g_vld_q;
      i_vld_q     <= h_vld_q;
      j_vld_q     <= i_vld_q;
      k_vld_q     <= j_vld_q;
      l_vld_q     <= k_vld_q;
      out_valid_q <= l_vld_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= in_data_i;
      s2_q <= s2_d;
      s3_q <= s3_d;

      s4_q.side <= s3_q.side;
      s4_q.cx   <= s3_q.cx;
      s4_q.cy   <= s3_q.cy;
      s4_q.mb2  <= s3_q.mb2;
      s4_q.t2   <= s3_q.t2;
      s4_q.xsq  <= 62'(s3_q.cx) * 62'(s3_q.cx);
      s4_q.ysq  <= 62'(s3_q.cy) * 62'(s3_q.cy);

      sq_q[0].side <= s4_q.side;
      sq_q[0].cx   <= s4_q.cx;
      sq_q[0].cy   <= s4_q.cy;
      sq_q[0].mb2  <= s4_q.mb2;
      sq_q[0].t2   <= s4_q.t2;
      sq_q[0].rem  <= 64'(s4_q.xsq) + 64'(s4_q.ysq);
      sq_q[0].root <= '0;
      for (int g = 0; g < SQ_N; g++) begin
        sq_q[g+1] <= sq_step(sq_q[g], SQ_N - 1 - g);
      end

      // Seed each remainder with the dividend bits above the 31 quotient steps
      dv_q[0].side   <= sq_q[SQ_N].side;
      dv_q[0].mag    <= sq_q[SQ_N].root;
      dv_q[0].t2     <= sq_q[SQ_N].t2;
      dv_q[0].nx_num <= {sq_q[SQ_N].cx, 30'd0} + 62'(sq_q[SQ_N].root[31:1]);
      dv_q[0].ny_num <= {sq_q[SQ_N].cy, 30'd0} + 62'(sq_q[SQ_N].root[31:1]);
      dv_q[0].m_num  <= {1'b0, sq_q[SQ_N].mb2, 30'd0} + 63'(sq_q[SQ_N].t2[31:1]);
      dv_q[0].rx     <= 32'(({sq_q[SQ_N].cx, 30'd0} + 62'(sq_q[SQ_N].root[31:1])) >> 31);
      dv_q[0].ry     <= 32'(({sq_q[SQ_N].cy, 30'd0} + 62'(sq_q[SQ_N].root[31:1])) >> 31);
      dv_q[0].rm     <= 32'(({1'b0, sq_q[SQ_N].mb2, 30'd0} + 63'(sq_q[SQ_N].t2[31:1])) >> 31);
      dv_q[0].qx     <= '0;
      dv_q[0].qy     <= '0;
      dv_q[0].qm     <= '0;
      for (int g = 0; g < DV_N; g++) begin
        dv_q[g+1] <= dv_step(dv_q[g], DV_N - 1 - g);
      end

      g_q <= g_d;

      h_q.side <= g_q.side;
      h_q.ux   <= g_q.ux;
      h_q.uy   <= g_q.uy;
      h_q.ga   <= g_q.ga;
      h_q.gb   <= g_q.gb;
      h_q.pdx  <= g_q.dx * g_q.ux;
      h_q.pdy  <= g_q.dy * g_q.uy;

      i_q.side <= h_q.side;
      i_q.ux   <= h_q.ux;
      i_q.uy   <= h_q.uy;
      i_q.ga   <= h_q.ga;
      i_q.gb   <= h_q.gb;
      i_q.d    <= 36'(rnd30(72'(h_q.pdx))) + 36'(rnd30(72'(h_q.pdy)));

      j_q.side <= i_q.side;
      j_q.ux   <= i_q.ux;
      j_q.uy   <= i_q.uy;
      j_q.qa   <= i_q.d * $signed({1'b0, i_q.ga});
      j_q.qb   <= i_q.d * $signed({1'b0, i_q.gb});

      k_q.side <= j_q.side;
      k_q.ux   <= j_q.ux;
      k_q.uy   <= j_q.uy;
      k_q.pa   <= 38'(rnd30(72'(j_q.qa)));
      k_q.pb   <= 38'(rnd30(72'(j_q.qb)));

      l_q.side <= k_q.side;
      l_q.pax  <= k_q.pa * k_q.ux;
      l_q.pay  <= k_q.pa * k_q.uy;
      l_q.pbx  <= k_q.pb * k_q.ux;
      l_q.pby  <= k_q.pb * k_q.uy;

      out_q <= out_d;
    end
  end

  // The normalised squared length is at least 2^60, so the root reaches 2^30
  `IC2D_ASSERT_NOW(a_sqrt_range, sq_vld_q[SQ_N] && sq_q[SQ_N].side.status == ST_OK, sq_q[SQ_N].root >= 32'(ONE30), "square root below unit range")
  // Unit vector components and mass ratio never exceed one
  `IC2D_ASSERT_NOW(a_quot_range, dv_vld_q[DV_N] && dv_q[DV_N].side.status == ST_OK, dv_q[DV_N].qx <= ONE30 && dv_q[DV_N].qy <= ONE30 && dv_q[DV_N].qm <= ONE30, "quotient above one")
  // A frozen pipeline keeps its last stage
  `IC2D_ASSERT_NXT(a_freeze, !en, $stable(l_vld_q) && $stable(out_valid_q), "pipeline moved while stalled")

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// Impulse collision 2D unit testbench
// Streams contact pairs through the unit with random gaps on both channels and
// checks every result against a bit-accurate predictor. A stimulus table comes
// first, then random contacts, across several restitution settings.
// ----------------------------------------------------------------------------
module tb_top;
  import ic2d_pkg::*;

  localparam int LATENCY   = 76;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 850;

  typedef struct {
    ic2d_in_t  item;
    logic      known;
    ic2d_out_t res;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  ic2d_in_t   in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  ic2d_out_t  out_data_o;

  ic2d_out_t  velocity_queue[$];
  logic [15:0] coeff_e = 16'd32768;
  int         errors = 0;
  int         cycle = 0;
  int         stall_left = 0;
  logic       stim_done = 1'b0;
  stim_row_t  rows[$];

  impulse_collision_2d_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned mag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // a*b/2^30, round to nearest, ties away from zero
  function automatic longint scale30(longint a, longint b);
    logic neg;
    longint unsigned ua, ub, hi, lo, r;
    neg = (a < 0) != (b < 0);
    ua = mag(a);
    ub = mag(b);
    hi = (ua >> 32) * ub;
    lo = (ua & 64'hFFFF_FFFF) * ub;
    r = (hi << 2) + (lo >> 30) + ((lo >> 29) & 64'd1);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic resting(longint x, longint y);
    longint unsigned ax, ay;
    ax = mag(x);
    ay = mag(y);
    if (ax >= 64'd32768 || ay >= 64'd32768) return 1'b0;
    return ax * ax + ay * ay < REST_LIMIT;
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic ic2d_out_t bounce(ic2d_in_t c, logic [15:0] e_reg);
    ic2d_out_t o;
    longint nx, ny, vax, vay, vbx, vby, ax, ay, bx, by, ux, uy, d, pa, pb;
    longint unsigned cx, cy, m, ma, mb, tot, nm, ma2, mb2, t2, ra, rb, e, ga, gb;
    int sh;
    nx = c.normal_x; ny = c.normal_y;
    vax = c.vel_a_x; vay = c.vel_a_y; vbx = c.vel_b_x; vby = c.vel_b_y;
    ma = 64'(c.mass_a); mb = 64'(c.mass_b);
    ax = vax; ay = vay; bx = vbx; by = vby;
    cx = mag(nx); cy = mag(ny);
    m = cx > cy ? cx : cy;
    tot = ma + mb;
    o.status = ST_OK;
    if (resting(vax, vay) && resting(vbx, vby)) begin
      o.status = ST_REST;
    end else if (m == 0 || tot == 0) begin
      o.status = ST_ZERO;
    end else begin
      while (m >= 64'd1 << 31) begin m >>= 1; cx >>= 1; cy >>= 1; end
      while (m < 64'd1 << 30) begin m <<= 1; cx <<= 1; cy <<= 1; end
      nm = root_floor(cx * cx + cy * cy);
      ux = longint'(((cx << 30) + nm / 2) / nm);
      uy = longint'(((cy << 30) + nm / 2) / nm);
      if (nx < 0) ux = -ux;
      if (ny < 0) uy = -uy;
      sh = 0;
      while ((tot >> sh) >= 64'd1 << 32) sh++;
      ma2 = ma >> sh; mb2 = mb >> sh; t2 = ma2 + mb2;
      ra = ((mb2 << 30) + t2 / 2) / t2;
      rb = (64'd1 << 30) - ra;
      e = e_reg > 16'd32768 ? 64'd32768 : 64'(e_reg);
      ga = (ra * (64'd32768 + e) + 64'd16384) >> 15;
      gb = (rb * (64'd32768 + e) + 64'd16384) >> 15;
      d = scale30(vbx - vax, ux) + scale30(vby - vay, uy);
      pa = scale30(d, longint'(ga));
      pb = scale30(d, longint'(gb));
      ax = vax + scale30(pa, ux);
      ay = vay + scale30(pa, uy);
      bx = vbx - scale30(pb, ux);
      by = vby - scale30(pb, uy);
    end
    o.new_vel_a_x = clamp32(ax);
    o.new_vel_a_y = clamp32(ay);
    o.new_vel_b_x = clamp32(bx);
    o.new_vel_b_y = clamp32(by);
    return o;
  endfunction

  function automatic logic [31:0] rnd_field();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic ic2d_in_t rnd_contact();
    ic2d_in_t c;
    c.normal_x = rnd_field();
    c.normal_y = rnd_field();
    c.vel_a_x = rnd_field();
    c.vel_a_y = rnd_field();
    c.vel_b_x = rnd_field();
    c.vel_b_y = rnd_field();
    c.mass_a = $urandom_range(0, 9) == 0 ? 32'd0 : rnd_field();
    c.mass_b = $urandom_range(0, 9) == 0 ? 32'd0 : rnd_field();
    if ($urandom_range(0, 19) == 0) begin
      c.vel_a_x = $urandom_range(0, 40); c.vel_a_y = -$urandom_range(0, 40);
      c.vel_b_x = -$urandom_range(0, 40); c.vel_b_y = $urandom_range(0, 40);
    end
    if ($urandom_range(0, 29) == 0) c.normal_x = 0;
    if ($urandom_range(0, 29) == 0) c.normal_y = 0;
    return c;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3);
  endfunction

  function automatic stim_row_t mk(ic2d_in_t c, logic known, ic2d_out_t r);
    stim_row_t s;
    s.item = c; s.known = known; s.res = r;
    return s;
  endfunction

  // Valid stays high between back-to-back transfers; drop it only for a gap
  task automatic push(ic2d_in_t c, logic known, ic2d_out_t r);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    velocity_queue.push_back(known ? r : bounce(c, coeff_e));
    in_data_i <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_and_write(logic [15:0] v);
    in_valid_i <= 1'b0;
    while (velocity_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    coeff_e = v;
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(5, 30);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= $urandom_range(0, 7) == 0 ? ($urandom_range(0, 1) == 1) : 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    ic2d_out_t want;
    cycle <= cycle + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (velocity_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        errors++;
      end else begin
        want = velocity_queue.pop_front();
        if (want.new_vel_a_x !== out_data_o.new_vel_a_x ||
            want.new_vel_a_y !== out_data_o.new_vel_a_y ||
            want.new_vel_b_x !== out_data_o.new_vel_b_x ||
            want.new_vel_b_y !== out_data_o.new_vel_b_y ||
            want.status !== out_data_o.status) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data_o);
          errors++;
        end
      end
    end
  end

  initial begin
    ic2d_in_t c;
    ic2d_out_t r;
    logic [15:0] e_set[4];
    e_set = '{16'd0, 16'hFFFF, 16'd16384, 16'd32768};
    // rest: everything returned unchanged
    c = '{32'h10000, 32'h0, 32'h10000, 32'sd10, -32'sd20, 32'h10000, 32'sd3, 32'sd0};
    r = '{32'sd10, -32'sd20, 32'sd3, 32'sd0, ST_REST};
    rows.push_back(mk(c, 1'b1, r));
    // zero normal
    c = '{32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h10000, -32'sh10000, 32'h0};
    r = '{32'h10000, 32'h0, -32'sh10000, 32'h0, ST_ZERO};
    rows.push_back(mk(c, 1'b1, r));
    // zero total mass
    c = '{32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0, -32'sh10000, 32'h0};
    r = '{32'h10000, 32'h0, -32'sh10000, 32'h0, ST_ZERO};
    rows.push_back(mk(c, 1'b1, r));
    // equal masses, head-on, e=1: velocities swap
    c = '{32'h10000, 32'h0, 32'h10000, 32'h10000, 32'h0, 32'h10000, -32'sh10000, 32'h0};
    r = '{-32'sh10000, 32'h0, 32'h10000, 32'h0, ST_OK};
    rows.push_back(mk(c, 1'b1, r));
    r = '0;
    // extremes, one zero mass, separating, unnormalised normals
    rows.push_back(mk('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0, r));
    rows.push_back(mk('{32'h8000_0000, 32'h8000_0000, 32'h0, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 0, r));
    rows.push_back(mk('{32'h1, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h50000,
                        32'h3}, 0, r));
    rows.push_back(mk('{32'h3, 32'hFFFF_FFFC, 32'h20000, 32'hFFFB_0000, 32'h1234,
                        32'h8000, 32'h50000, 32'hFFFF_0000}, 0, r));
    rows.push_back(mk('{32'h0, 32'h7FFF_FFFF, 32'h1, 32'h0, 32'h8000, 32'hFFFF_FFFF,
                        32'h0, 32'h0}, 0, r));
    rows.push_back(mk('{32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h00FF_0000,
                        32'h0, 32'h8000_0000, 32'h0, 32'h40}, 0, r));
    rows.push_back(mk('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, r));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) push(rows[i].item, rows[i].known, rows[i].res);
    for (int k = 0; k < 4; k++) begin
      drain_and_write(e_set[k]);
      foreach (rows[i]) if (!rows[i].known) push(rows[i].item, 1'b0, r);
      for (int n = 0; n < N_RANDOM / 4; n++) push(rnd_contact(), 1'b0, r);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (velocity_queue.size() != 0 && cycle < MAX_CYCLE) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && velocity_queue.size() == 0) begin
      $display("PASS impulse_collision_2d_unit");
    end else begin
      $display("FAIL impulse_collision_2d_unit");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycle > MAX_CYCLE) begin
      $display("FAIL impulse_collision_2d_unit");
      $finish;
    end
  end

endmodule
